[rtl/trss_pkg.sv]
// Shared types and constants for the timed relay state sequencer.
// No dependencies; compile first.
package trss_pkg;

  localparam int STATE_IDX_W = 3;   // width of a state index on ports and in entries
  localparam int TIME_W      = 32;
  localparam int FLAGS_W     = 8;
  localparam int RELAY_W     = 4;
  localparam int BATCH_W     = 16;
  localparam int ENTRY_W     = 47;
  localparam int CFG_IDX_W   = 3;

  // entry packing
  localparam int TIME_LSB   = 0;
  localparam int FLAGS_LSB  = 32;
  localparam int NEXT_LSB   = 40;
  localparam int RELAY_LSB  = 43;

  // flag fields
  localparam int EVAP_LSB   = 0;    // bits 1:0
  localparam int COUNT_BIT  = 2;
  localparam int BIN_LSB    = 3;    // bits 4:3

  // datapath commands issued by the controller
  typedef struct packed {
    logic latch;        // capture request fields, clear step count and fault
    logic enter_start;  // enter the requested start state
    logic enter_next;   // enter the active entry's next state
    logic tick;         // advance the millisecond timer
    logic apply;        // drive the active entry's relay pattern
    logic set_fault;    // mark the chain as aborted
    logic load_out;     // capture the result register
  } dp_cmd_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic leave;        // active state must be left
    logic over_limit;   // chain has run past the step limit
    logic out_free;     // result register can take a new result
  } dp_status_t;

endpackage

[rtl/trss_item_if.sv]
// Request channel carrying one input item.
// Depends on trss_pkg.
interface trss_item_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [trss_pkg::STATE_IDX_W-1:0] start_state;
  logic                             evaporator_level;
  logic                             bin_level;

  modport source (output valid, mode, start_state, evaporator_level, bin_level, input ready);
  modport sink   (input valid, mode, start_state, evaporator_level, bin_level, output ready);
endinterface

[rtl/trss_result_if.sv]
// Request channel carrying one result item.
// Depends on trss_pkg.
interface trss_result_if;
  logic                             valid;
  logic                             ready;
  logic [trss_pkg::RELAY_W-1:0]     relay_pins;
  logic [trss_pkg::STATE_IDX_W-1:0] current_state;
  logic [trss_pkg::STATE_IDX_W-1:0] current_mode;
  logic [trss_pkg::BATCH_W-1:0]     batch_total;
  logic [trss_pkg::TIME_W-1:0]      time_left;
  logic                             loop_fault;

  modport source (output valid, relay_pins, current_state, current_mode, batch_total,
                  time_left, loop_fault, input ready);
  modport sink   (input valid, relay_pins, current_state, current_mode, batch_total,
                  time_left, loop_fault, output ready);
endinterface

[rtl/trss_cfg_if.sv]
// Configuration write channel: table entry index and data.
// Depends on trss_pkg.
interface trss_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [trss_pkg::CFG_IDX_W-1:0] index;
  logic [trss_pkg::ENTRY_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/trss_datapath.sv]
// Datapath: state table, timer, batch counter, step counter, result register.
// Depends on trss_pkg; driven by trss_ctrl commands.
module trss_datapath #(
  parameter int STATES     = 8,
  parameter int LOOP_LIMIT = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  trss_pkg::dp_cmd_t                cmd,
  output trss_pkg::dp_status_t             status,
  // request fields
  input  logic [trss_pkg::STATE_IDX_W-1:0] start_state,
  input  logic                             evaporator_level,
  input  logic                             bin_level,
  // config write
  input  logic                             cfg_we,
  input  logic [trss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trss_pkg::ENTRY_W-1:0]     cfg_data,
  // result
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [trss_pkg::RELAY_W-1:0]     relay_pins,
  output logic [trss_pkg::STATE_IDX_W-1:0] current_state,
  output logic [trss_pkg::STATE_IDX_W-1:0] current_mode,
  output logic [trss_pkg::BATCH_W-1:0]     batch_total,
  output logic [trss_pkg::TIME_W-1:0]      time_left,
  output logic                             loop_fault
);
  import trss_pkg::*;

  localparam int IDXW = (STATES > 1) ? $clog2(STATES) : 1;
  localparam int SW   = $clog2(LOOP_LIMIT + 2);

  function automatic logic [IDXW-1:0] clamp_idx(input logic [STATE_IDX_W-1:0] idx);
    logic [IDXW-1:0] r;
    if (int'(idx) >= STATES) r = IDXW'(STATES - 1);
    else                     r = idx[IDXW-1:0];
    return r;
  endfunction

  logic [ENTRY_W-1:0]     entries [STATES];
  logic [RELAY_W-1:0]     relay_pattern;
  logic [IDXW-1:0]        active;
  logic [TIME_W-1:0]      elapsed;
  logic [BATCH_W-1:0]     batch_count;
  logic [STATE_IDX_W-1:0] mode_held;
  logic [SW-1:0]          steps;
  logic                   fault;
  logic [STATE_IDX_W-1:0] start_q;
  logic                   evap_q;
  logic                   bin_q;

  logic [ENTRY_W-1:0]     cur;
  logic [TIME_W-1:0]      cur_time;
  logic [FLAGS_W-1:0]     cur_flags;
  logic [STATE_IDX_W-1:0] cur_next;
  logic [RELAY_W-1:0]     cur_relays;
  logic [IDXW-1:0]        tgt;
  logic [FLAGS_W-1:0]     tgt_flags;
  logic [TIME_W-1:0]      left_now;

  assign cur        = entries[active];
  assign cur_time   = cur[TIME_LSB +: TIME_W];
  assign cur_flags  = cur[FLAGS_LSB +: FLAGS_W];
  assign cur_next   = cur[NEXT_LSB +: STATE_IDX_W];
  assign cur_relays = cur[RELAY_LSB +: RELAY_W];

  assign tgt       = clamp_idx(cmd.enter_start ? start_q : cur_next);
  assign tgt_flags = entries[tgt][FLAGS_LSB +: FLAGS_W];

  // condition code c matches level (~c & 3); codes 0 and 1 never match a 1-bit level
  assign status.leave = (elapsed >= cur_time) ||
                        (~cur_flags[EVAP_LSB +: 2] == {1'b0, evap_q}) ||
                        (~cur_flags[BIN_LSB +: 2] == {1'b0, bin_q});
  assign status.over_limit = (steps > SW'(LOOP_LIMIT));
  assign status.out_free   = !out_valid || out_ready;

  assign left_now = (cur_time > elapsed) ? (cur_time - elapsed) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STATES; i++) entries[i] <= '0;
      relay_pattern <= '0;
      active        <= '0;
      elapsed       <= '0;
      batch_count   <= '0;
      mode_held     <= '0;
      steps         <= '0;
      fault         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we && (int'(cfg_index) < STATES)) begin
        entries[cfg_index[IDXW-1:0]] <= cfg_data;
      end
      if (cmd.latch) begin
        steps <= '0;
        fault <= 1'b0;
      end
      if (cmd.enter_start) begin
        mode_held <= start_q;
      end
      if (cmd.enter_start || cmd.enter_next) begin
        active  <= tgt;
        elapsed <= '0;
        if (tgt_flags[COUNT_BIT]) batch_count <= batch_count + 1'b1;
        if (cmd.enter_next) steps <= steps + 1'b1;
      end
      if (cmd.tick && (elapsed != '1)) begin
        elapsed <= elapsed + 1'b1;
      end
      if (cmd.apply) begin
        relay_pattern <= cur_relays;
      end
      if (cmd.set_fault) begin
        fault <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      start_q <= start_state;
      evap_q  <= evaporator_level;
      bin_q   <= bin_level;
    end
    if (cmd.load_out) begin
      relay_pins    <= ~relay_pattern;
      current_state <= STATE_IDX_W'(active);
      current_mode  <= mode_held;
      batch_total   <= batch_count;
      time_left     <= left_now;
      loop_fault    <= fault;
    end
  end

endmodule

[rtl/trss_ctrl.sv]
// Controller FSM: sequences start, tick and state-chain steps.
// Depends on trss_pkg; drives trss_datapath through dp_cmd_t.
module trss_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_mode,
  output logic                 in_ready,
  input  trss_pkg::dp_status_t status,
  output trss_pkg::dp_cmd_t    cmd
);
  import trss_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_START = 8'b0000_0010,
    S_TICK  = 8'b0000_0100,
    S_TEST  = 8'b0000_1000,
    S_CHAIN = 8'b0001_0000,
    S_CHECK = 8'b0010_0000,
    S_APPLY = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } ctrl_state_t;

  ctrl_state_t state, state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = in_mode ? S_START : S_TICK;
        end
      end
      S_START: begin
        cmd.enter_start = 1'b1;
        state_next      = S_APPLY;
      end
      S_TICK: begin
        cmd.tick   = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        state_next = status.leave ? S_CHAIN : S_DONE;
      end
      S_CHAIN: begin
        cmd.enter_next = 1'b1;
        state_next     = S_CHECK;
      end
      S_CHECK: begin
        if (status.over_limit) begin
          cmd.set_fault = 1'b1;
          state_next    = S_DONE;
        end else if (status.leave) begin
          state_next = S_CHAIN;
        end else begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

[rtl/timed_relay_state_sequencer.sv]
// Timed relay state sequencer, top level.
// A start request passes START and APPLY; a tick passes TICK and TEST and, when the
// state must be left, CHAIN and CHECK for each chained state (N at most LOOP_LIMIT+1)
// and APPLY unless the chain runs away. Both end in DONE, which waits for the output
// register. One request at a time, taken only in IDLE; results wait in that register.
// Reset (rst, synchronous): table cleared, relays off, state 0, counters zero.
module timed_relay_state_sequencer #(
  parameter int STATES     = 8,
  parameter int LOOP_LIMIT = 8
) (
  input logic    clk,
  input logic    rst,
  trss_item_if.sink     item,
  trss_result_if.source result,
  trss_cfg_if.sink      cfg
);
  import trss_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Table writes taken each cycle not in reset; user must write only while idle.
  assign cfg.ready = !rst;

  // Controller: accepts a request when idle, then walks the tick / chain
  // sequence and hands the result to the output register.
  trss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_mode  (item.mode),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: state table, timer, batch counter, chain step counter and the
  // result register that parts the request side from the result side.
  trss_datapath #(
    .STATES     (STATES),
    .LOOP_LIMIT (LOOP_LIMIT)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .start_state      (item.start_state),
    .evaporator_level (item.evaporator_level),
    .bin_level        (item.bin_level),
    .cfg_we           (cfg.valid && cfg.ready),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .out_ready        (result.ready),
    .out_valid        (result.valid),
    .relay_pins       (result.relay_pins),
    .current_state    (result.current_state),
    .current_mode     (result.current_mode),
    .batch_total      (result.batch_total),
    .time_left        (result.time_left),
    .loop_fault       (result.loop_fault)
  );

endmodule

[verif/timed_relay_state_sequencer_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for timed_relay_state_sequencer: a directed plan, then random
// tick/start requests over several table settings, scored against an in-bench model.
// Depends on trss_pkg, trss_item_if, trss_result_if, trss_cfg_if and the RTL top.
module timed_relay_state_sequencer_tb;
  import trss_pkg::*;

  localparam int NUM_STATES   = 8;
  localparam int LOOP_MAX     = 8;
  localparam bit MODE_TICK    = 1'b0;
  localparam bit MODE_START   = 1'b1;
  localparam int DIR_ROWS     = 25;
  localparam int SEG_COUNT    = 6;
  localparam int SEG_ITEMS    = 240;
  localparam int START_PCT    = 12;     // share of start requests in random traffic
  localparam int HOLD_CYCLES  = 150;    // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES = 30;     // covers the worst-case chain
  localparam int CYCLE_LIMIT  = 400000;

  typedef logic [ENTRY_W-1:0] entry_t;
  typedef entry_t entry_set_t [NUM_STATES];

  typedef struct packed {
    logic [RELAY_W-1:0]     pins;
    logic [STATE_IDX_W-1:0] state;
    logic [STATE_IDX_W-1:0] mode;
    logic [BATCH_W-1:0]     batch;
    logic [TIME_W-1:0]      tleft;
    logic                   fault;
  } seq_result_t;

  // One directed request; typed rows carry a hand-written result
  typedef struct {
    bit                   mode;
    bit [STATE_IDX_W-1:0] start;
    bit                   evap;
    bit                   bin;
    bit                   typed;
    seq_result_t          want;
  } stim_row_t;

  logic clk;
  logic rst;

  trss_item_if   item_ch ();
  trss_result_if res_ch ();
  trss_cfg_if    cfg_ch ();

  timed_relay_state_sequencer #(
    .STATES     (NUM_STATES),
    .LOOP_LIMIT (LOOP_MAX)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Sequencer model: table copy plus the live state of the block
  // ---------------------------------------------------------------------------
  entry_t                 model_ent [NUM_STATES];
  logic [RELAY_W-1:0]     model_relays;
  logic [STATE_IDX_W-1:0] model_idx;
  logic [TIME_W-1:0]      model_elapsed;
  logic [BATCH_W-1:0]     model_batch;
  logic [STATE_IDX_W-1:0] model_mode;

  seq_result_t  pending_q [$];   // results still owed by the block, oldest first
  int           err_cnt       = 0;
  int           send_idle_pct = 22;
  int           recv_idle_pct = 77;
  bit           hold_rx       = 1'b0;
  int unsigned  cycle_cnt;
  stim_row_t    plan [DIR_ROWS];

  function automatic logic [TIME_W-1:0] dur_of(logic [STATE_IDX_W-1:0] idx);
    return model_ent[idx][TIME_LSB +: TIME_W];
  endfunction

  function automatic logic [FLAGS_W-1:0] flags_of(logic [STATE_IDX_W-1:0] idx);
    return model_ent[idx][FLAGS_LSB +: FLAGS_W];
  endfunction

  function automatic logic [STATE_IDX_W-1:0] next_of(logic [STATE_IDX_W-1:0] idx);
    return model_ent[idx][NEXT_LSB +: STATE_IDX_W];
  endfunction

  function automatic logic [RELAY_W-1:0] relays_of(logic [STATE_IDX_W-1:0] idx);
    return model_ent[idx][RELAY_LSB +: RELAY_W];
  endfunction

  // Entering a state: indexes past the table read as the last entry,
  // timer clears, count flag bumps the batch total (wraps at 16 bits).
  function automatic void enter_step(logic [STATE_IDX_W-1:0] idx);
    logic [FLAGS_W-1:0] f;
    model_idx = (idx >= NUM_STATES) ? STATE_IDX_W'(NUM_STATES - 1) : idx;
    model_elapsed = '0;
    f = flags_of(model_idx);
    if (f[COUNT_BIT]) model_batch = model_batch + 1'b1;
  endfunction

  // Time reached, or a thermostat condition matches its pin level.
  // A condition c matches level (~c & 3), so codes 0 and 1 never match.
  function automatic bit must_leave(bit evap, bit bin);
    logic [FLAGS_W-1:0] f;
    logic [1:0]         evap_want;
    logic [1:0]         bin_want;
    f         = flags_of(model_idx);
    evap_want = ~f[EVAP_LSB +: 2];
    bin_want  = ~f[BIN_LSB +: 2];
    if (model_elapsed >= dur_of(model_idx)) return 1'b1;
    if (evap_want == {1'b0, evap}) return 1'b1;
    if (bin_want == {1'b0, bin}) return 1'b1;
    return 1'b0;
  endfunction

  // Applies one request to the model and returns the result it owes
  function automatic seq_result_t advance_relay_seq(bit mode, bit [STATE_IDX_W-1:0] start,
                                                    bit evap, bit bin);
    seq_result_t        r;
    int                 steps;
    bit                 fault;
    logic [TIME_W-1:0]  t;
    fault = 1'b0;
    if (mode == MODE_START) begin
      // start: thermostat levels ignored, relays applied at once
      model_mode = start;
      enter_step(start);
      model_relays = relays_of(model_idx);
    end else begin
      if (model_elapsed != '1) model_elapsed = model_elapsed + 1'b1;   // saturates
      if (must_leave(evap, bin)) begin
        steps = 0;
        // chain through next indexes; runaway stops in the last entered
        // state and leaves the relays as they were
        do begin
          enter_step(next_of(model_idx));
          steps++;
          fault = (steps > LOOP_MAX);
        end while (!fault && must_leave(evap, bin));
        if (!fault) model_relays = relays_of(model_idx);
      end
    end
    t       = dur_of(model_idx);
    r.pins  = ~model_relays;                 // pins are active low
    r.state = model_idx;
    r.mode  = model_mode;
    r.batch = model_batch;
    r.tleft = (t > model_elapsed) ? t - model_elapsed : '0;
    r.fault = fault;
    return r;
  endfunction

  function automatic stim_row_t mk_req(bit mode, bit [STATE_IDX_W-1:0] start, bit evap,
                                       bit bin);
    stim_row_t row;
    row.mode  = mode;
    row.start = start;
    row.evap  = evap;
    row.bin   = bin;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic drain_results();
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Writes all eight entries; only called while the block is idle
  task automatic load_entries(entry_set_t s);
    for (int i = 0; i < NUM_STATES; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= CFG_IDX_W'(i);
      cfg_ch.data  <= s[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      model_ent[i] = s[i];
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Offers one request, with random idle cycles ahead of it. Valid stays
  // high between back-to-back requests, so it gets one update per step.
  task automatic send_req(stim_row_t row);
    seq_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid            <= 1'b1;
    item_ch.mode             <= row.mode;
    item_ch.start_state      <= row.start;
    item_ch.evaporator_level <= row.evap;
    item_ch.bin_level        <= row.bin;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    pred = advance_relay_seq(row.mode, row.start, row.evap, row.bin);
    pending_q.push_back(row.typed ? row.want : pred);
  endtask

  task automatic run_random(int count);
    stim_row_t row;
    row = mk_req(MODE_TICK, '0, 1'b0, 1'b0);
    repeat (count) begin
      row.mode  = ($urandom_range(0, 99) < START_PCT) ? MODE_START : MODE_TICK;
      row.start = STATE_IDX_W'($urandom_range(0, NUM_STATES - 1));
      row.evap  = 1'($urandom_range(0, 1));
      row.bin   = 1'($urandom_range(0, 1));
      send_req(row);
    end
    item_ch.valid <= 1'b0;
    drain_results();
  endtask

  // Mostly short durations so chains fire often; some long and maximal ones
  task automatic make_random_entries(output entry_set_t s);
    int                pick;
    logic [TIME_W-1:0] d;
    for (int i = 0; i < NUM_STATES; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)       d = $urandom_range(0, 6);
      else if (pick == 7) d = $urandom_range(7, 40);
      else if (pick == 8) d = $urandom;
      else                d = '1;
      s[i] = {RELAY_W'($urandom_range(0, 15)), STATE_IDX_W'($urandom_range(0, 7)),
              FLAGS_W'($urandom_range(0, 255)), d};
    end
  endtask

  task automatic cmp_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      err_cnt++;
    end
  endtask

  task automatic check_result();
    seq_result_t want;
    if (pending_q.size() == 0) begin
      $error("result request with no result pending");
      err_cnt++;
    end else begin
      want = pending_q.pop_front();
      cmp_field("relay_pins", TIME_W'(want.pins), TIME_W'(res_ch.relay_pins));
      cmp_field("current_state", TIME_W'(want.state), TIME_W'(res_ch.current_state));
      cmp_field("current_mode", TIME_W'(want.mode), TIME_W'(res_ch.current_mode));
      cmp_field("batch_total", TIME_W'(want.batch), TIME_W'(res_ch.batch_total));
      cmp_field("time_left", want.tleft, res_ch.time_left);
      cmp_field("loop_fault", TIME_W'(want.fault), TIME_W'(res_ch.loop_fault));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, watchdog, result sink
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timed_relay_state_sequencer verification failed");
    $finish;
  end

  // Sink: samples at the edge, then picks ready for the next cycle.
  // hold_rx forces a long stall so the output register fills up.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) check_result();
      res_ch.ready <= !hold_rx && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    entry_set_t set_a;
    entry_set_t set_x;

    rst                      <= 1'b1;
    item_ch.valid            <= 1'b0;
    item_ch.mode             <= MODE_TICK;
    item_ch.start_state      <= '0;
    item_ch.evaporator_level <= 1'b0;
    item_ch.bin_level        <= 1'b0;
    cfg_ch.valid             <= 1'b0;
    cfg_ch.index             <= '0;
    cfg_ch.data              <= '0;

    for (int i = 0; i < NUM_STATES; i++) model_ent[i] = '0;
    model_relays  = '0;
    model_idx     = '0;
    model_elapsed = '0;
    model_batch   = '0;
    model_mode    = '0;

    // Directed table, packed {relays, next, flags, time}:
    // 0 -> 1 after 3 ms; 1 counts; 2 has max time and both thermostats armed;
    // 3 <-> 4 with zero time is a runaway loop; 5 leaves on bin low;
    // 6 leaves on evaporator high; 7 has dead conditions plus junk flag bits.
    set_a[0] = {4'b0001, 3'd1, 8'h00, 32'd3};
    set_a[1] = {4'b1010, 3'd2, 8'h04, 32'd2};
    set_a[2] = {4'b1111, 3'd3, 8'h13, 32'hFFFF_FFFF};
    set_a[3] = {4'b0100, 3'd4, 8'h00, 32'd0};
    set_a[4] = {4'b0010, 3'd3, 8'h04, 32'd0};
    set_a[5] = {4'b1000, 3'd6, 8'h18, 32'd5};
    set_a[6] = {4'b0110, 3'd7, 8'h02, 32'd10};
    set_a[7] = {4'b0011, 3'd0, 8'hE5, 32'd4};

    // Rows 0-1 run on the cleared table; set_a is loaded before row 2
    plan[0]  = mk_req(MODE_TICK,  3'd0, 1'b0, 1'b0);   // zero table: runaway
    plan[1]  = mk_req(MODE_START, 3'd0, 1'b0, 1'b0);
    plan[2]  = mk_req(MODE_START, 3'd2, 1'b0, 1'b1);   // levels ignored on start
    plan[3]  = mk_req(MODE_TICK,  3'd5, 1'b1, 1'b0);   // holds in 2
    plan[4]  = mk_req(MODE_TICK,  3'd0, 1'b0, 1'b0);   // evap match -> 3/4 runaway
    plan[5]  = mk_req(MODE_START, 3'd0, 1'b1, 1'b1);
    plan[6]  = mk_req(MODE_TICK,  3'd7, 1'b1, 1'b1);
    plan[7]  = mk_req(MODE_TICK,  3'd0, 1'b0, 1'b0);
    plan[8]  = mk_req(MODE_TICK,  3'd0, 1'b1, 1'b0);   // time up -> 1, counts
    plan[9]  = mk_req(MODE_TICK,  3'd0, 1'b0, 1'b1);
    plan[10] = mk_req(MODE_TICK,  3'd0, 1'b1, 1'b0);   // -> 2, holds
    plan[11] = mk_req(MODE_TICK,  3'd0, 1'b1, 1'b1);   // bin match -> runaway
    plan[12] = mk_req(MODE_START, 3'd5, 1'b1, 1'b1);
    plan[13] = mk_req(MODE_TICK,  3'd0, 1'b0, 1'b1);
    plan[14] = mk_req(MODE_TICK,  3'd0, 1'b1, 1'b0);   // 5 -> 6 -> 7 chain
    plan[15] = mk_req(MODE_TICK,  3'd0, 1'b0, 1'b0);
    plan[16] = mk_req(MODE_TICK,  3'd0, 1'b1, 1'b1);
    plan[17] = mk_req(MODE_TICK,  3'd0, 1'b0, 1'b1);
    plan[18] = mk_req(MODE_TICK,  3'd0, 1'b1, 1'b0);   // 7 times out -> 0
    plan[19] = mk_req(MODE_START, 3'd7, 1'b0, 1'b0);
    plan[20] = mk_req(MODE_START, 3'd3, 1'b1, 1'b0);   // start skips the tests
    plan[21] = mk_req(MODE_TICK,  3'd0, 1'b0, 1'b1);
    plan[22] = mk_req(MODE_START, 3'd6, 1'b1, 1'b1);
    plan[23] = mk_req(MODE_TICK,  3'd0, 1'b0, 1'b1);
    plan[24] = mk_req(MODE_TICK,  3'd0, 1'b1, 1'b1);

    // Hand-checked rows: reset table, max duration, runaway with batch bumps
    plan[0].typed = 1'b1;
    plan[0].want  = {4'hF, 3'd0, 3'd0, 16'd0, 32'd0, 1'b1};
    plan[1].typed = 1'b1;
    plan[1].want  = {4'hF, 3'd0, 3'd0, 16'd0, 32'd0, 1'b0};
    plan[2].typed = 1'b1;
    plan[2].want  = {4'h0, 3'd2, 3'd2, 16'd0, 32'hFFFF_FFFF, 1'b0};
    plan[4].typed = 1'b1;
    plan[4].want  = {4'h0, 3'd3, 3'd2, 16'd4, 32'd0, 1'b1};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == 2) begin
        item_ch.valid <= 1'b0;
        drain_results();
        load_entries(set_a);
      end
      send_req(plan[i]);
    end
    item_ch.valid <= 1'b0;
    drain_results();

    // Random part: sender-light/receiver-heavy idling, then swapped, then none
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 77;
        recv_idle_pct = 22;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (seg == 1) begin
        for (int i = 0; i < NUM_STATES; i++) set_x[i] = '0;   // every tick runs away
      end else if (seg == 3) begin
        for (int i = 0; i < NUM_STATES; i++) set_x[i] = '1;   // max time, all flags
      end else begin
        make_random_entries(set_x);
      end
      load_entries(set_x);
      if (seg == 4) begin
        fork
          begin
            hold_rx <= 1'b1;
            for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
            hold_rx <= 1'b0;
          end
        join_none
      end
      run_random(SEG_ITEMS);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("timed_relay_state_sequencer verification clean");
    end else begin
      $display("timed_relay_state_sequencer verification failed");
    end
    $finish;
  end

endmodule
